>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define SRD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define SRD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/srd_pkg.sv
// ----------------------------------------------------------------------------
// String escape decoder package
// Types, character codes and helper functions shared by the decoder files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srd_pkg;

  // Decoder phase.
  typedef enum logic [2:0] {
    PhNormal,
    PhEsc,
    PhOct1,
    PhOct2,
    PhHex0,
    PhHex1
  } phase_e;

  // Configuration register indexes.
  localparam logic [1:0] CfgRawMode       = 2'd0;
  localparam logic [1:0] CfgUnicodeMode   = 2'd1;
  localparam logic [1:0] CfgIgnoreEscapes = 2'd2;

  // Character codes.
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChSquote    = 8'h27;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChLowB      = 8'h62;
  localparam logic [7:0] ChLowF      = 8'h66;
  localparam logic [7:0] ChLowT      = 8'h74;
  localparam logic [7:0] ChLowN      = 8'h6E;
  localparam logic [7:0] ChLowR      = 8'h72;
  localparam logic [7:0] ChLowV      = 8'h76;
  localparam logic [7:0] ChLowA      = 8'h61;
  localparam logic [7:0] ChLowX      = 8'h78;

  // Control bytes produced by the single-letter escapes.
  localparam logic [7:0] CtlBackspace = 8'h08;
  localparam logic [7:0] CtlFormFeed  = 8'h0C;
  localparam logic [7:0] CtlTab       = 8'h09;
  localparam logic [7:0] CtlLineFeed  = 8'h0A;
  localparam logic [7:0] CtlReturn    = 8'h0D;
  localparam logic [7:0] CtlVtab      = 8'h0B;
  localparam logic [7:0] CtlBell      = 8'h07;

  // Result queue depth; must be a power of two, at least 4.
  localparam int unsigned ResFifoDepth = 4;

  // One input item.
  typedef struct packed {
    logic       last_byte;
    logic [7:0] in_byte;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic       end_of_str;
    logic       run_last;
    logic       has_byte;
    logic [7:0] out_byte;
  } res_t;

  // Results of one decoded item, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    res_t       res1;
    res_t       res0;
  } dec_out_t;

  function automatic logic is_octal(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h37);
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  // Value of a hex digit; only meaningful when is_hex() holds.
  function automatic logic [3:0] hex_value(logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

endpackage

>>> src/string_escape_decoder.sv
// ----------------------------------------------------------------------------
// String escape decoder
// Decodes the body bytes of a Python string literal into the bytes they mean.
// ----------------------------------------------------------------------------
// The block takes one body byte per item on the slave stream, with tlast on
// the final byte of the string, and delivers decoded bytes on the master
// stream. When any of the raw, unicode or ignore-escapes registers is set,
// bytes pass through unchanged; otherwise backslash escapes are decoded
// (control letters, quotes, backslash-newline, one to three octal digits,
// two hex digits after \x). The item carrying tlast always produces a final
// result with tlast set; if nothing else is left to say, that result is a
// bare end marker with tuser[0] low and a zero data byte. A new input item
// can be taken every cycle while the result queue has two free entries: an
// accepted item is held in the input register, is decoded once the queue
// has that room, and its results are written into the result queue, from
// which they are offered on the master side. Sustained throughput is one
// item per cycle while each item yields one result and the master side does
// not stall; an item that yields two results needs two transfers on the
// single output port, and a four-entry result queue soaks this up, holding
// the input back only once fewer than two entries are free. Configuration
// writes are always accepted and should be made only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module string_escape_decoder import srd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,

  // Input stream. tdata: [7:0] in_byte. tlast: last_byte.
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,
  input  logic       s_axis_tlast,

  // Result stream. tdata: [7:0] out_byte. tuser: [0] has_byte, [1] run_last.
  // tlast: end of the whole string.
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,
  output logic [1:0] m_axis_tuser,
  output logic       m_axis_tlast,

  // Configuration write channel.
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic       cfg_data_i
);

  // Mode registers.
  logic raw_mode_q, unicode_mode_q, ignore_escapes_q;

  // Input register.
  logic     in_valid_q;
  in_item_t in_item_q;

  logic     fire;
  logic     space2;
  dec_out_t dec;
  res_t     head;

  // The configuration port never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_mode_q       <= 1'b0;
      unicode_mode_q   <= 1'b0;
      ignore_escapes_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgRawMode:       raw_mode_q       <= cfg_data_i;
        CfgUnicodeMode:   unicode_mode_q   <= cfg_data_i;
        CfgIgnoreEscapes: ignore_escapes_q <= cfg_data_i;
        default: ;  // Writes beyond the register list are dropped.
      endcase
    end
  end

  // The held item is decoded once the queue can take both of its possible
  // results; the input register refills in the same cycle.
  assign fire          = in_valid_q && space2;
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q <= '{last_byte: s_axis_tlast, in_byte: s_axis_tdata};
    end
  end

  srd_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .copy_i (raw_mode_q | unicode_mode_q | ignore_escapes_q),
    .item_i (in_item_q),
    .dec_o  (dec)
  );

  srd_res_fifo u_res_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (fire),
    .dec_i    (dec),
    .space2_o (space2),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .res_o    (head)
  );

  assign m_axis_tdata = head.out_byte;
  assign m_axis_tuser = {head.run_last, head.has_byte};
  assign m_axis_tlast = head.end_of_str;

endmodule

>>> src/srd_decode.sv
// ----------------------------------------------------------------------------
// Escape decode stage
// Holds the escape phase and turns one registered byte into zero to two results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srd_decode import srd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  logic     copy_i,
  input  in_item_t item_i,
  output dec_out_t dec_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] partial_q, partial_d;

  res_t       res [2];
  logic [1:0] cnt;
  logic       do_plain;
  logic [7:0] c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhNormal;
      partial_q <= '0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      partial_q <= partial_d;
    end
  end

  always_comb begin
    res[0]    = '0;
    res[1]    = '0;
    cnt       = 2'd0;
    do_plain  = 1'b0;
    phase_d   = phase_q;
    partial_d = partial_q;
    c         = item_i.in_byte;

    if (copy_i) begin
      res[0]    = '{end_of_str: 1'b0, run_last: 1'b0, has_byte: 1'b1, out_byte: c};
      cnt       = 2'd1;
      phase_d   = PhNormal;
      partial_d = '0;
    end else begin
      case (phase_q)
        PhEsc: begin
          phase_d = PhNormal;
          cnt     = 2'd1;
          res[0].has_byte = 1'b1;
          case (c)
            ChNewline:                       cnt = 2'd0;
            ChBackslash, ChSquote, ChDquote: res[0].out_byte = c;
            ChLowB:                          res[0].out_byte = CtlBackspace;
            ChLowF:                          res[0].out_byte = CtlFormFeed;
            ChLowT:                          res[0].out_byte = CtlTab;
            ChLowN:                          res[0].out_byte = CtlLineFeed;
            ChLowR:                          res[0].out_byte = CtlReturn;
            ChLowV:                          res[0].out_byte = CtlVtab;
            ChLowA:                          res[0].out_byte = CtlBell;
            ChLowX: begin
              cnt     = 2'd0;
              phase_d = PhHex0;
            end
            default: begin
              if (is_octal(c)) begin
                cnt       = 2'd0;
                partial_d = {5'd0, c[2:0]};
                phase_d   = PhOct1;
              end else begin
                // Unknown escape keeps the backslash and the character.
                res[0].out_byte = ChBackslash;
                res[1] = '{end_of_str: 1'b0, run_last: 1'b0, has_byte: 1'b1, out_byte: c};
                cnt    = 2'd2;
              end
            end
          endcase
        end
        PhOct1, PhOct2: begin
          if (is_octal(c)) begin
            if (phase_q == PhOct1) begin
              partial_d = {partial_q[4:0], c[2:0]};
              phase_d   = PhOct2;
            end else begin
              res[0] = '{end_of_str: 1'b0, run_last: 1'b0, has_byte: 1'b1,
                         out_byte: {partial_q[4:0], c[2:0]}};
              cnt     = 2'd1;
              phase_d = PhNormal;
            end
          end else begin
            // Escape cut short: flush the value, then treat the byte as plain.
            res[0]   = '{end_of_str: 1'b0, run_last: 1'b0, has_byte: 1'b1,
                         out_byte: partial_q};
            cnt      = 2'd1;
            do_plain = 1'b1;
          end
        end
        PhHex0: begin
          if (is_hex(c)) begin
            partial_d = {4'd0, hex_value(c)};
            phase_d   = PhHex1;
          end else begin
            do_plain = 1'b1;
          end
        end
        PhHex1: begin
          if (is_hex(c)) begin
            res[0] = '{end_of_str: 1'b0, run_last: 1'b0, has_byte: 1'b1,
                       out_byte: {partial_q[3:0], hex_value(c)}};
            cnt     = 2'd1;
            phase_d = PhNormal;
          end else begin
            do_plain = 1'b1;
          end
        end
        default: do_plain = 1'b1;
      endcase

      if (do_plain) begin
        if (c == ChBackslash) begin
          phase_d = PhEsc;
        end else begin
          res[cnt[0]] = '{end_of_str: 1'b0, run_last: 1'b0, has_byte: 1'b1, out_byte: c};
          cnt         = cnt + 2'd1;
          phase_d     = PhNormal;
        end
      end
    end

    if (item_i.last_byte) begin
      // Close out whatever escape is still pending at the end of the string.
      if (phase_d == PhEsc) begin
        res[cnt[0]] = '{end_of_str: 1'b0, run_last: 1'b0, has_byte: 1'b1,
                        out_byte: ChBackslash};
        cnt         = cnt + 2'd1;
      end else if ((phase_d == PhOct1) || (phase_d == PhOct2)) begin
        res[cnt[0]] = '{end_of_str: 1'b0, run_last: 1'b0, has_byte: 1'b1,
                        out_byte: partial_d};
        cnt         = cnt + 2'd1;
      end
      phase_d   = PhNormal;
      partial_d = '0;
      if (cnt == 2'd0) begin
        res[0] = '0;
        cnt    = 2'd1;
      end
      res[cnt[1]].end_of_str = 1'b1;
    end

    if (cnt != 2'd0) begin
      res[cnt[1]].run_last = 1'b1;
    end

    dec_o.count = cnt;
    dec_o.res0  = res[0];
    dec_o.res1  = res[1];
  end

endmodule

>>> src/srd_res_fifo.sv
// ----------------------------------------------------------------------------
// Result queue
// Small queue that takes up to two results per cycle and delivers one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srd_res_fifo import srd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  dec_out_t dec_i,
  output logic     space2_o,
  output logic     valid_o,
  input  logic     ready_i,
  output res_t     res_o
);

  localparam int unsigned PtrW = $clog2(ResFifoDepth);

  res_t              mem_q [ResFifoDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]     count_q, count_d;
  logic [1:0]        n_push;
  logic              pop;
  logic [PtrW-1:0]   wr_ptr_p1;

  assign n_push    = push_i ? dec_i.count : 2'd0;
  assign pop       = valid_o && ready_i;
  assign wr_ptr_p1 = wr_ptr_q + PtrW'(1);
  assign valid_o   = (count_q != '0);
  assign res_o     = mem_q[rd_ptr_q];
  assign space2_o  = (count_q <= (PtrW+1)'(ResFifoDepth - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(n_push);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    count_d  = count_q + (PtrW+1)'(n_push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_ptr_q] <= dec_i.res0;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_ptr_p1] <= dec_i.res1;
    end
  end

endmodule

>>> src/srd_checker.sv
// ----------------------------------------------------------------------------
// String escape decoder checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // A stalled result stays offered.
  `SRD_ASSERT(a_valid_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result withdrawn while stalled")

  // A stalled result keeps its payload.
  `SRD_ASSERT(a_data_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")

  // The end of a string also ends the run of its last item.
  `SRD_ASSERT(a_end_is_run_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1], "string end without run last")

  // A result without a byte is only the bare end marker, with zero data.
  `SRD_ASSERT(a_bare_marker, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && m_axis_tuser[1] && (m_axis_tdata == 8'h00), "malformed bare end marker")

endmodule

bind string_escape_decoder srd_checker u_srd_checker (.*);
